@@ design/positional_list_store_core_macros.svh @@
// assertion macros shared by the list store checker
`ifndef POSITIONAL_LIST_STORE_CORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_CORE_MACROS_SVH

// same-cycle implication under reset
`define PLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/pls_pkg.sv @@
// shared types and constants for the positional list store
`timescale 1ns / 1ps
package pls_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int GRP    = 8;
	localparam int GRP_W  = $clog2(GRP);
	localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
	localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int SEL_W  = GRP_W + NGRP_W;

	typedef enum logic [2:0] {
		OP_APPEND      = 3'd0,
		OP_INSERT      = 3'd1,
		OP_REMOVE_LAST = 3'd2,
		OP_REMOVE_AT   = 3'd3,
		OP_READ_AT     = 3'd4,
		OP_READ_LAST   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_POST
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] position;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic [6:0]  element_count;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic pick;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic read_go;
	} dp_status_t;

endpackage

@@ design/pls_ctrl.sv @@
// sequencing state machine for the list store
`timescale 1ns / 1ps
module pls_ctrl import pls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   valid_q, valid_d;
	logic   out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
		end
	end

	assign out_free  = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		valid_d = valid_q && rsp_stall;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.read_go ? S_READ : S_POST;
			end
			S_READ: begin
				cmd.pick = 1'b1;
				state_d  = S_POST;
			end
			S_POST: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					valid_d  = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/pls_datapath.sv @@
// element shift chain, count, read selection tree and result register
`timescale 1ns / 1ps
module pls_datapath import pls_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  request_t   req,
	output dp_status_t sts,
	output result_t    rsp
);

	logic [2:0]           op_q;
	logic [15:0]          pos_q;
	logic [WORD_BITS-1:0] word_q;
	logic [CNT_W-1:0]     count_q;
	status_t              status_q;
	logic [WORD_BITS-1:0] rd_q;
	result_t              rsp_q;

	logic [WORD_BITS-1:0] cells_q [DEPTH];
	logic [WORD_BITS-1:0] cand [NGRP][GRP];
	logic [WORD_BITS-1:0] grp_s1 [NGRP];
	logic [NGRP_W-1:0]    grp_sel_s1;

	logic             is_ins, is_rem, is_read;
	logic             full, empty, past_end;
	logic             do_ins, do_rem;
	logic [IDX_W-1:0] last_idx, ins_idx, sel_idx;
	logic [SEL_W-1:0] sel;
	status_t          status_d;

	always_comb begin
		is_ins   = op_q inside {OP_APPEND, OP_INSERT};
		is_rem   = op_q inside {OP_REMOVE_LAST, OP_REMOVE_AT};
		is_read  = op_q inside {OP_READ_AT, OP_READ_LAST};
		full     = (count_q == CNT_W'(DEPTH));
		empty    = (count_q == '0);
		past_end = (pos_q >= 16'(count_q));
		last_idx = IDX_W'(count_q - CNT_W'(1));
		ins_idx  = (op_q == OP_APPEND || past_end) ? IDX_W'(count_q) : IDX_W'(pos_q);
		sel_idx  = (op_q == OP_REMOVE_LAST || op_q == OP_READ_LAST || past_end) ?
			last_idx : IDX_W'(pos_q);
		sel      = SEL_W'(sel_idx);
		do_ins   = cmd.exec && is_ins && !full;
		do_rem   = cmd.exec && is_rem && !empty;
		if (is_ins && full) begin
			status_d = ST_FULL;
		end else if ((is_rem || is_read) && empty) begin
			status_d = ST_EMPTY;
		end else begin
			status_d = ST_DONE;
		end
	end

	assign sts.read_go = is_read && !empty;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.operation;
			pos_q  <= req.position;
			word_q <= WORD_BITS'(req.value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// insert shifts cells above ins_idx up, remove cells from sel_idx down
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] below, above;
		if (i > 0) begin : g_below
			assign below = cells_q[i-1];
		end else begin : g_nobelow
			assign below = '0;
		end
		if (i < DEPTH - 1) begin : g_above
			assign above = cells_q[i+1];
		end else begin : g_noabove
			assign above = cells_q[i];
		end
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (IDX_W'(i) == ins_idx) begin
					cells_q[i] <= word_q;
				end else if (IDX_W'(i) > ins_idx) begin
					cells_q[i] <= below;
				end
			end else if (do_rem) begin
				if (IDX_W'(i) >= sel_idx) begin
					cells_q[i] <= above;
				end
			end
		end
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		for (genvar k = 0; k < GRP; k++) begin : g_lane
			if (g * GRP + k < DEPTH) begin : g_real
				assign cand[g][k] = cells_q[g * GRP + k];
			end else begin : g_pad
				assign cand[g][k] = '0;
			end
		end
	end

	// two-level read selection: within a group, then across groups
	always_ff @(posedge clk) begin
		if (cmd.exec && sts.read_go) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= cand[g][sel[GRP_W-1:0]];
			end
			grp_sel_s1 <= sel[SEL_W-1:GRP_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			rd_q     <= '0;
		end else if (cmd.pick) begin
			rd_q <= grp_s1[grp_sel_s1];
		end
		if (cmd.emit) begin
			rsp_q.status        <= status_q;
			rsp_q.read_value    <= 32'(rd_q);
			rsp_q.element_count <= 7'(count_q);
		end
	end

	assign rsp = rsp_q;

endmodule

@@ design/positional_list_store_core.sv @@
// top level of the positional list store
`timescale 1ns / 1ps
// Ordered list of up to DEPTH words with append, insert, remove and read by position.
// Each accepted item gives exactly one result item. An insert, a remove, a refused
// request or an unknown operation code goes through the execute and post states;
// a successful read has a read state between them, as the element goes through a
// registered two-level selection tree (eight cells per group, then across groups).
// Cells from the slot up shift or load in the execute state. The result sits in an
// output register, so the next item is taken while it waits; only the step that
// loads the output register waits on rsp_stall. The list is empty after reset.
module positional_list_store_core import pls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  request_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output result_t  rsp
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pls_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

@@ design/pls_checker.sv @@
// port-level checks for the positional list store
`timescale 1ns / 1ps
`include "positional_list_store_core_macros.svh"
module pls_checker import pls_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input request_t req,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input result_t  rsp
);

	`PLS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall,
		rsp_valid && $stable(rsp), "stalled result item changed")

	`PLS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall,
		req_stall, "item accepted while previous item still in work")

	`PLS_ASSERT_NOW(a_empty_result, clk, arst_n, rsp_valid && rsp.status == ST_EMPTY,
		rsp.element_count == 7'd0 && rsp.read_value == 32'd0, "bad empty refusal")

	`PLS_ASSERT_NOW(a_full_result, clk, arst_n, rsp_valid && rsp.status == ST_FULL,
		rsp.element_count == 7'(DEPTH) && rsp.read_value == 32'd0, "bad full refusal")

endmodule

bind positional_list_store_core pls_checker u_pls_checker (.*);

@@ verif/positional_list_store_core_tb.sv @@
// self-checking testbench for the positional list store: directed table, then random phases
`timescale 1ns / 1ps
module positional_list_store_core_tb;
	import pls_pkg::*;

	// codes outside the operation set, which must leave the list alone
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int HOLD_AT_ITEM = 250;
	localparam int HOLD_CYCLES = 150;
	localparam int DRILL_LEN = 21;

	typedef enum {PH_MIX, PH_GROW, PH_SHRINK} phase_t;

	typedef struct packed {
		request_t rq;
		logic     fixed;
		result_t  want;
	} drill_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	request_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	result_t  rsp;

	// shadow copy of the list
	logic [31:0] list_words [DEPTH];
	int          list_count;
	result_t     pending_results [$];
	int          error_count;
	int          items_sent;
	bit          steady_stretch;

	drill_row_t drill_rows [DRILL_LEN] = '{
		'{'{OP_READ_LAST,   16'h0000, 32'h0000_0000}, 1'b1, '{ST_EMPTY, 32'h0, 7'd0}},
		'{'{OP_REMOVE_LAST, 16'h0000, 32'h0000_0000}, 1'b1, '{ST_EMPTY, 32'h0, 7'd0}},
		'{'{OP_REMOVE_AT,   16'h0000, 32'h0000_0000}, 1'b1, '{ST_EMPTY, 32'h0, 7'd0}},
		'{'{OP_READ_AT,     16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '{ST_EMPTY, 32'h0, 7'd0}},
		'{'{OP_SPARE_LO,    16'h0000, 32'h0000_0000}, 1'b1, '{ST_DONE,  32'h0, 7'd0}},
		'{'{OP_INSERT,      16'h0005, 32'hFFFF_FFFF}, 1'b1, '{ST_DONE,  32'h0, 7'd1}},
		'{'{OP_APPEND,      16'hFFFF, 32'h0000_0000}, 1'b1, '{ST_DONE,  32'h0, 7'd2}},
		'{'{OP_INSERT,      16'h0000, 32'hA5A5_A5A5}, 1'b1, '{ST_DONE,  32'h0, 7'd3}},
		'{'{OP_READ_AT,     16'h0000, 32'h0000_0000}, 1'b1, '{ST_DONE, 32'hA5A5_A5A5, 7'd3}},
		'{'{OP_READ_AT,     16'hFFFF, 32'h0000_0000}, 1'b1, '{ST_DONE,  32'h0, 7'd3}},
		'{'{OP_READ_LAST,   16'h0000, 32'h0000_0000}, 1'b1, '{ST_DONE,  32'h0, 7'd3}},
		'{'{OP_INSERT,      16'h0001, 32'h5A5A_5A5A}, 1'b0, '0},
		'{'{OP_READ_AT,     16'h0001, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_REMOVE_AT,   16'hFFFF, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_REMOVE_AT,   16'h0000, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_SPARE_HI,    16'hFFFF, 32'hFFFF_FFFF}, 1'b0, '0},
		'{'{OP_READ_AT,     16'h0002, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_REMOVE_LAST, 16'h0000, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_READ_LAST,   16'h0000, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_REMOVE_LAST, 16'h0000, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_READ_AT,     16'h0000, 32'h0000_0000}, 1'b1, '{ST_EMPTY, 32'h0, 7'd0}}
	};

	phase_t phase_plan [9] = '{PH_GROW, PH_MIX, PH_SHRINK, PH_GROW, PH_SHRINK,
		PH_MIX, PH_GROW, PH_MIX, PH_SHRINK};

	positional_list_store_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// applies one request to the shadow list and returns the result it should give
	function automatic result_t apply_list_request(request_t rq);
		result_t res;
		int      last;
		int      idx;
		int      i;
		res = '0;
		last = (list_count == 0) ? 0 : list_count - 1;
		case (rq.operation)
			OP_APPEND, OP_INSERT: begin
				if (list_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					idx = (rq.operation == OP_APPEND || rq.position >= list_count) ?
						list_count : int'(rq.position);
					for (i = list_count; i > idx; i--)
						list_words[i] = list_words[i - 1];
					list_words[idx] = rq.value;
					list_count++;
				end
			end
			OP_REMOVE_LAST, OP_REMOVE_AT: begin
				if (list_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					idx = (rq.operation == OP_REMOVE_LAST || rq.position >= list_count) ?
						last : int'(rq.position);
					for (i = idx; i + 1 < list_count; i++)
						list_words[i] = list_words[i + 1];
					list_count--;
				end
			end
			OP_READ_AT, OP_READ_LAST: begin
				if (list_count == 0) begin
					res.status = ST_EMPTY;
				end else if (rq.operation == OP_READ_LAST || rq.position >= list_count) begin
					res.read_value = list_words[last];
				end else begin
					res.read_value = list_words[rq.position];
				end
			end
			default: ;
		endcase
		res.element_count = 7'(list_count);
		return res;
	endfunction

	function automatic logic [2:0] pick_operation(phase_t ph);
		int r;
		r = $urandom_range(99);
		case (ph)
			PH_GROW: begin
				if (r < 45) return OP_APPEND;
				if (r < 80) return OP_INSERT;
				if (r < 88) return OP_READ_AT;
				if (r < 92) return OP_READ_LAST;
				if (r < 95) return OP_REMOVE_LAST;
				if (r < 98) return OP_REMOVE_AT;
			end
			PH_SHRINK: begin
				if (r < 40) return OP_REMOVE_AT;
				if (r < 75) return OP_REMOVE_LAST;
				if (r < 85) return OP_READ_AT;
				if (r < 90) return OP_READ_LAST;
				if (r < 95) return OP_APPEND;
				if (r < 98) return OP_INSERT;
			end
			default: begin
				if (r < 18) return OP_APPEND;
				if (r < 36) return OP_INSERT;
				if (r < 52) return OP_REMOVE_LAST;
				if (r < 70) return OP_REMOVE_AT;
				if (r < 84) return OP_READ_AT;
				if (r < 96) return OP_READ_LAST;
			end
		endcase
		return ($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
	endfunction

	function automatic request_t random_request(phase_t ph);
		request_t rq;
		int       r;
		rq.operation = pick_operation(ph);
		r = $urandom_range(99);
		// mostly positions around the live range, one past the end included
		if (r < 70)
			rq.position = 16'($urandom_range(list_count));
		else if (r < 80)
			rq.position = 16'h0000;
		else if (r < 90)
			rq.position = 16'hFFFF;
		else
			rq.position = 16'($urandom);
		r = $urandom_range(99);
		if (r < 5)
			rq.value = 32'h0000_0000;
		else if (r < 10)
			rq.value = 32'hFFFF_FFFF;
		else
			rq.value = $urandom;
		return rq;
	endfunction

	function automatic bit idle_roll();
		return !steady_stretch && ($urandom_range(99) < 17);
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		error_count++;
		$display("%0t mismatch %s: expected %0h got %0h", $time, what, want, got);
	endtask

	// entered at a falling edge, leaves at a falling edge with valid still high
	task automatic send_item(input request_t rq, input logic fixed, input result_t want);
		result_t predicted;
		while (idle_roll()) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= rq;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = apply_list_request(rq);
		pending_results.push_back(fixed ? want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result item, count", 32'h0,
					32'(rsp.element_count));
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch("status", 32'(want.status), 32'(rsp.status));
				if (rsp.read_value !== want.read_value)
					flag_mismatch("read_value", want.read_value, rsp.read_value);
				if (rsp.element_count !== want.element_count)
					flag_mismatch("element_count", 32'(want.element_count),
						32'(rsp.element_count));
			end
		end
	end

	// result side: random stalls plus one long hold while the sender keeps going
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= idle_roll();
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int row;
		int ph;
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		list_count = 0;
		error_count = 0;
		items_sent = 0;
		steady_stretch = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (row = 0; row < DRILL_LEN; row++)
			send_item(drill_rows[row].rq, drill_rows[row].fixed, drill_rows[row].want);
		wait_for_results();
		// grow phases run into the full list, shrink phases into the empty one
		for (ph = 0; ph < 9; ph++) begin
			steady_stretch = (ph == 5);
			for (n = 0; n < 100; n++)
				send_item(random_request(phase_plan[ph]), 1'b0, '0);
			wait_for_results();
		end
		steady_stretch = 0;
		repeat (10) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/pls_pkg.sv
design/pls_ctrl.sv
design/pls_datapath.sv
design/positional_list_store_core.sv
design/pls_checker.sv
verif/positional_list_store_core_tb.sv
